FILE: sv/isq_pkg.sv
// ============================================================================
// isq_pkg: shared types and constants for the interval set block
// Request/result structs, table sizing, controller command/status bundles.
// ============================================================================
`default_nettype none
package isq_pkg;

    localparam int MAX_INTERVALS = 16;
    localparam int IDX_W = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
    localparam int VAL_W = 33;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic        func;
        logic [31:0] range_a;
        logic [31:0] range_b;
    } req_t;

    typedef struct packed {
        logic contained;
        logic table_full;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture request, ptr = 0
        logic rd_ptr;      // read entry ptr (registered)
        logic rd_prev;     // read entry ptr-1
        logic rd_lo;       // read entry lo
        logic rd_hi1;      // read entry hi-1
        logic ptr_inc;
        logic ptr_dec;
        logic ptr_to_cnt;
        logic ptr_to_hi;
        logic lo_at_ptr;   // lo = ptr
        logic lo_at_prev;  // lo = ptr-1
        logic hi_at_ptr;   // hi = ptr
        logic hi_at_prev;  // hi = ptr-1
        logic keep_ms;     // ms = min(read start, s)
        logic wr_shift;    // write read entry at ptr
        logic wr_new;      // write new range at lo, count++
        logic wr_merge;    // write merged entry at lo
        logic wr_pack;     // write read entry at ptr-(hi-lo-1)
        logic cnt_pack;    // count -= hi-lo-1
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_query;
        logic empty;
        logic ptr_at_n;    // ptr == count
        logic ptr_at_lo;   // ptr == lo
        logic end_lt_s;    // read entry end < s
        logic start_le_e;  // read entry start <= e
        logic covers;      // read entry covers [s,e)
        logic lo_eq_hi;
        logic full;        // count == MAX
    } sts_t;

endpackage
`default_nettype wire

FILE: sv/isq_datapath.sv
// ============================================================================
// isq_datapath: interval table and compare logic
// Holds the table memory, count, pointers and the registered entry read.
// ============================================================================
`default_nettype none
module isq_datapath (
    input  wire             clk,
    input  wire             rst_n,
    input  isq_pkg::req_t   req,
    input  isq_pkg::cmd_t   cmd,
    output isq_pkg::sts_t   sts
);
    localparam int IW = isq_pkg::IDX_W;
    localparam int CW = isq_pkg::CNT_W;
    localparam int VW = isq_pkg::VAL_W;

    logic [VW-1:0] mem_s [isq_pkg::MAX_INTERVALS];
    logic [VW-1:0] mem_e [isq_pkg::MAX_INTERVALS];

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] ptr_reg;
    logic [CW-1:0] lo_reg, hi_reg;
    logic          func_reg, empty_reg;
    logic [VW-1:0] s_reg, e_reg;
    logic [VW-1:0] rs_reg, re_reg;
    logic [VW-1:0] ms_reg;

    logic [CW-1:0] gap;
    logic [CW-1:0] ptr_prev;
    logic [CW-1:0] wr_addr, rd_addr;
    logic [VW-1:0] wr_s, wr_e;
    logic          wr_en, rd_en;
    logic [VW-1:0] a_ext, b_ext;

    assign gap      = hi_reg - lo_reg - CW'(1);
    assign ptr_prev = ptr_reg - CW'(1);
    assign a_ext    = {1'b0, req.range_a};
    assign b_ext    = {1'b0, req.range_b};
    assign rd_en    = cmd.rd_ptr | cmd.rd_prev | cmd.rd_lo | cmd.rd_hi1;

    // one write port, one read address per cycle
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = ptr_reg;
        wr_s    = rs_reg;
        wr_e    = re_reg;
        rd_addr = ptr_reg;
        if (cmd.wr_shift)
        begin
            wr_en   = 1'b1;  // rs/re hold entry ptr-1
        end
        else if (cmd.wr_new)
        begin
            wr_en   = 1'b1;
            wr_addr = lo_reg;
            wr_s    = s_reg;
            wr_e    = e_reg;
        end
        else if (cmd.wr_merge)
        begin
            wr_en   = 1'b1;
            wr_addr = lo_reg;
            wr_s    = ms_reg;
            wr_e    = (re_reg > e_reg) ? re_reg : e_reg;   // re = entry hi-1 end
        end
        else if (cmd.wr_pack)
        begin
            wr_en   = 1'b1;
            wr_addr = ptr_reg - gap;   // rs/re hold entry ptr
        end
        if (cmd.rd_prev)
            rd_addr = ptr_prev;
        else if (cmd.rd_lo)
            rd_addr = lo_reg;
        else if (cmd.rd_hi1)
            rd_addr = hi_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_s[wr_addr[IW-1:0]] <= wr_s;
            mem_e[wr_addr[IW-1:0]] <= wr_e;
        end
        if (rd_en)
        begin
            rs_reg <= mem_s[rd_addr[IW-1:0]];
            re_reg <= mem_e[rd_addr[IW-1:0]];
        end
        if (cmd.keep_ms)
            ms_reg <= (rs_reg < s_reg) ? rs_reg : s_reg;   // rs = entry lo start
        if (cmd.load)
        begin
            func_reg  <= req.func;
            empty_reg <= (req.range_a == req.range_b);
            if (req.range_a <= req.range_b)
            begin
                s_reg <= a_ext;
                e_reg <= b_ext;
            end
            else
            begin
                s_reg <= b_ext + VW'(1);
                e_reg <= a_ext + VW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ptr_reg <= '0;
            lo_reg  <= '0;
            hi_reg  <= '0;
        end
        else
        begin
            if (cmd.lo_at_ptr)
                lo_reg <= ptr_reg;
            else if (cmd.lo_at_prev)
                lo_reg <= ptr_prev;
            if (cmd.hi_at_ptr)
                hi_reg <= ptr_reg;
            else if (cmd.hi_at_prev)
                hi_reg <= ptr_prev;
            if (cmd.load)
                ptr_reg <= '0;
            else if (cmd.ptr_inc)
                ptr_reg <= ptr_reg + CW'(1);
            else if (cmd.ptr_dec)
                ptr_reg <= ptr_prev;
            else if (cmd.ptr_to_cnt)
                ptr_reg <= cnt_reg;
            else if (cmd.ptr_to_hi)
                ptr_reg <= hi_reg;
            if (cmd.wr_new)
                cnt_reg <= cnt_reg + CW'(1);
            else if (cmd.cnt_pack)
                cnt_reg <= cnt_reg - gap;
        end
    end

    always_comb
    begin
        sts.is_query   = (func_reg == isq_pkg::FUNC_QUERY);
        sts.empty      = empty_reg;
        sts.ptr_at_n   = (ptr_reg == cnt_reg);
        sts.ptr_at_lo  = (ptr_reg == lo_reg);
        sts.end_lt_s   = (re_reg < s_reg);
        sts.start_le_e = (rs_reg <= e_reg);
        sts.covers     = (rs_reg <= s_reg) && (re_reg >= e_reg);
        sts.lo_eq_hi   = (lo_reg == hi_reg);
        sts.full       = (cnt_reg == CW'(isq_pkg::MAX_INTERVALS));
    end
endmodule
`default_nettype wire

FILE: sv/isq_ctrl.sv
// ============================================================================
// isq_ctrl: sequencer for query, insert and merge passes
// Walks the table one entry at a time through the datapath read port.
// ============================================================================
`default_nettype none
module isq_ctrl (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  wire             out_stall,
    output isq_pkg::rsp_t   rsp,
    output isq_pkg::cmd_t   cmd,
    input  isq_pkg::sts_t   sts
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_QRD   = 4'd2;
    localparam logic [3:0] S_QCHK  = 4'd3;   // entry ptr-1 in read regs
    localparam logic [3:0] S_LORD  = 4'd4;
    localparam logic [3:0] S_LOCHK = 4'd5;
    localparam logic [3:0] S_HIRD  = 4'd6;
    localparam logic [3:0] S_HICHK = 4'd7;
    localparam logic [3:0] S_DEC   = 4'd8;   // lo==hi? insert : merge
    localparam logic [3:0] S_INS   = 4'd9;
    localparam logic [3:0] S_INSWR = 4'd10;
    localparam logic [3:0] S_MRDHI = 4'd11;
    localparam logic [3:0] S_MWR   = 4'd12;
    localparam logic [3:0] S_CRD   = 4'd13;
    localparam logic [3:0] S_CWR   = 4'd14;
    localparam logic [3:0] S_OUT   = 4'd15;

    logic [3:0] state_reg, state_next;
    logic       cont_reg, cont_next, full_reg, full_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign rsp.contained  = cont_reg;
    assign rsp.table_full = full_reg;

    always_comb
    begin
        state_next = state_reg;
        cont_next  = cont_reg;
        full_next  = full_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cont_next = 1'b0;
                full_next = 1'b0;
                if (sts.empty)
                    state_next = S_OUT;
                else
                    state_next = sts.is_query ? S_QRD : S_LORD;
            end
            S_QRD:
            begin
                if (sts.ptr_at_n)
                    state_next = S_OUT;
                else
                begin
                    cmd.rd_ptr  = 1'b1;
                    cmd.ptr_inc = 1'b1;
                    state_next  = S_QCHK;
                end
            end
            S_QCHK:
            begin
                if (sts.covers)
                begin
                    cont_next  = 1'b1;
                    state_next = S_OUT;
                end
                else
                    state_next = S_QRD;
            end
            S_LORD:
            begin
                if (sts.ptr_at_n)
                begin
                    // every entry ends before s: insert at the tail
                    cmd.lo_at_ptr = 1'b1;
                    cmd.hi_at_ptr = 1'b1;
                    state_next    = S_DEC;
                end
                else
                begin
                    cmd.rd_ptr  = 1'b1;
                    cmd.ptr_inc = 1'b1;
                    state_next  = S_LOCHK;
                end
            end
            S_LOCHK:
            begin
                if (sts.end_lt_s)
                    state_next = S_LORD;
                else
                begin
                    // entry ptr-1 is lo; its start decides whether it joins
                    cmd.lo_at_prev = 1'b1;
                    if (sts.start_le_e)
                    begin
                        cmd.hi_at_ptr = 1'b1;
                        state_next    = S_HIRD;
                    end
                    else
                    begin
                        cmd.hi_at_prev = 1'b1;
                        state_next     = S_DEC;
                    end
                end
            end
            S_HIRD:
            begin
                if (sts.ptr_at_n)
                    state_next = S_DEC;
                else
                begin
                    cmd.rd_ptr  = 1'b1;
                    cmd.ptr_inc = 1'b1;
                    state_next  = S_HICHK;
                end
            end
            S_HICHK:
            begin
                if (sts.start_le_e)
                begin
                    cmd.hi_at_ptr = 1'b1;
                    state_next    = S_HIRD;
                end
                else
                    state_next = S_DEC;
            end
            S_DEC:
            begin
                if (sts.lo_eq_hi)
                begin
                    if (sts.full)
                    begin
                        full_next  = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cmd.ptr_to_cnt = 1'b1;
                        state_next     = S_INS;
                    end
                end
                else
                begin
                    cmd.rd_lo  = 1'b1;
                    state_next = S_MRDHI;
                end
            end
            S_INS:
            begin
                if (sts.ptr_at_lo)
                begin
                    cmd.wr_new = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.rd_prev = 1'b1;
                    state_next  = S_INSWR;
                end
            end
            S_INSWR:
            begin
                cmd.wr_shift = 1'b1;
                cmd.ptr_dec  = 1'b1;
                state_next   = S_INS;
            end
            S_MRDHI:
            begin
                cmd.keep_ms = 1'b1;
                cmd.rd_hi1  = 1'b1;
                state_next  = S_MWR;
            end
            S_MWR:
            begin
                cmd.wr_merge  = 1'b1;
                cmd.ptr_to_hi = 1'b1;
                state_next    = S_CRD;
            end
            S_CRD:
            begin
                if (sts.ptr_at_n)
                begin
                    cmd.cnt_pack = 1'b1;
                    state_next   = S_OUT;
                end
                else
                begin
                    cmd.rd_ptr = 1'b1;
                    state_next = S_CWR;
                end
            end
            S_CWR:
            begin
                cmd.wr_pack = 1'b1;
                cmd.ptr_inc = 1'b1;
                state_next  = S_CRD;
            end
            S_OUT:
            begin
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cont_reg  <= 1'b0;
            full_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cont_reg  <= cont_next;
            full_reg  <= full_next;
        end
    end
endmodule
`default_nettype wire

FILE: sv/interval_set_merge_query.sv
// ============================================================================
// interval_set_merge_query: sorted disjoint interval table, add and query
// Controller plus datapath; one request at a time.
// ============================================================================
// Each request adds a half-open range to the table or asks whether one
// stored interval covers it; exactly one result comes back per request.
// A request holds the block from its accepting cycle until its result has
// been delivered, also while the result is stalled. The cost is set by the
// single registered read port of the table: every entry visited by the
// search, the insert shift or the compaction after a merge is read in a
// read state and checked or written in the state after it. An empty range
// answers without reading the table. The next request is taken in the
// cycle after the result has been delivered.
`default_nettype none
module interval_set_merge_query (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             in_valid,
    output logic            in_stall,
    input  isq_pkg::req_t   in_data,
    output logic            out_valid,
    input  wire             out_stall,
    output isq_pkg::rsp_t   out_data
);
    isq_pkg::cmd_t cmd;
    isq_pkg::sts_t sts;

    isq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .rsp       (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

    isq_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (in_data),
        .cmd   (cmd),
        .sts   (sts)
    );
endmodule
`default_nettype wire

FILE: sv/isq_checker.sv
// ============================================================================
// isq_checker: port-level checks for the interval set block
// Result field exclusivity, payload hold and request/result pacing.
// ============================================================================
`default_nettype none
module isq_checker (
    input wire           clk,
    input wire           rst_n,
    input wire           in_valid,
    input wire           in_stall,
    input isq_pkg::req_t in_data,
    input wire           out_valid,
    input wire           out_stall,
    input isq_pkg::rsp_t out_data
);
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.contained && out_data.table_full))
        else $error("both result flags set");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("request taken while result pending");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("stalled request changed");

    a_noimm: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !out_valid)
        else $error("result in cycle after request");
endmodule

bind interval_set_merge_query isq_checker u_isq_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
);
`default_nettype wire
